### rtl/csev_pkg.sv
package csev_pkg;

  // Fixed field widths of the block's ports.
  localparam int X_W    = 32;
  localparam int X_FRAC = 28;
  localparam int CNT_W  = 6;
  localparam int TOL_W  = 47;
  localparam int TERM_W = 48;

  // The shared multiplier takes one operand in chunks of this width.
  localparam int CHUNK_W    = 16;
  localparam int NUM_CHUNKS = TERM_W / CHUNK_W;

  // Quotient bits resolved per cycle by the iterative divider.
  localparam int DIV_RADIX_BITS = 4;

  typedef logic signed [TERM_W-1:0] term_t;

  localparam term_t TERM_MAX = {1'b0, {(TERM_W-1){1'b1}}};
  localparam term_t TERM_MIN = {1'b1, {(TERM_W-1){1'b0}}};

endpackage

### rtl/csev_div.sv
module csev_div #(
  parameter int NUM_W = 39,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int RB    = csev_pkg::DIV_RADIX_BITS;
  localparam int STEPS = (NUM_W + RB - 1) / RB;
  localparam int SH_W  = STEPS * RB;
  localparam int STW   = $clog2(STEPS + 1);

  logic [SH_W-1:0]  num_sh_r, num_sh_nxt;
  logic [SH_W-1:0]  quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [STW-1:0]   step_r;
  logic             busy_r;
  logic             done_r;

  // Restoring division, several quotient bits per cycle. The remainder
  // stays below the divisor, so every trial subtract is narrow.
  always_comb begin
    logic [DEN_W-1:0] rem_v;
    logic [DEN_W:0]   trial;
    logic [RB-1:0]    qbits;
    rem_v = rem_r;
    qbits = '0;
    for (int j = 0; j < RB; j++) begin
      trial = {rem_v, num_sh_r[SH_W-1-j]};
      if (trial >= {1'b0, den_r}) begin
        trial = trial - {1'b0, den_r};
        qbits[RB-1-j] = 1'b1;
      end
      rem_v = trial[DEN_W-1:0];
    end
    rem_nxt    = rem_v;
    quo_nxt    = {quo_r[SH_W-RB-1:0], qbits};
    num_sh_nxt = num_sh_r << RB;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        num_sh_r <= SH_W'(num);
        rem_r    <= '0;
        den_r    <= den;
        step_r   <= '0;
        busy_r   <= 1'b1;
      end else if (busy_r) begin
        num_sh_r <= num_sh_nxt;
        rem_r    <= rem_nxt;
        quo_r    <= quo_nxt;
        step_r   <= step_r + STW'(1);
        if (step_r == STW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r[NUM_W-1:0];

endmodule

### rtl/csev_mul.sv
module csev_mul #(
  parameter int B_W = 39
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            go,
  input  logic [csev_pkg::TERM_W-1:0]     a,
  input  logic [B_W-1:0]                  b,
  output logic                            done,
  output logic [csev_pkg::TERM_W+B_W-1:0] prod
);

  localparam int A_W  = csev_pkg::TERM_W;
  localparam int CK_W = csev_pkg::CHUNK_W;
  localparam int NCH  = csev_pkg::NUM_CHUNKS;
  localparam int P_W  = A_W + B_W;
  localparam int CNTW = $clog2(NCH + 1);

  logic [A_W-1:0]  a_r;
  logic [B_W-1:0]  b_r;
  logic [P_W-1:0]  acc_r, acc_nxt;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [CK_W+B_W-1:0] pp;

  // Chunks of a are taken from the top down, so the accumulator only
  // shifts by a fixed amount before each partial product is added.
  assign pp      = a_r[A_W-1 -: CK_W] * b_r;
  assign acc_nxt = (acc_r << CK_W) + P_W'(pp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        a_r    <= a;
        b_r    <= b;
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        a_r   <= a_r << CK_W;
        cnt_r <= cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(NCH - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

### rtl/cosine_series_evaluator.sv
// Evaluates the Maclaurin series of cos(x) for x in signed Q4.28, giving a
// saturated Q16.32 sum (FRAC_BITS fraction bits), the last term, the number
// of term updates and convergence and overflow flags. A transaction is
// accepted when start is high while busy is low; busy then stays high until
// the cycle in which out_valid pulses for one cycle with the result, and the
// receiver must take it in that cycle. Before the first update x is squared in
// the shared multiplier. Most of each update is spent in the iterative
// divider, which resolves four quotient bits per cycle; the chunked multiplier
// forms three partial products for each product.
module cosine_series_evaluator #(
  parameter int MAX_TERMS = 32,
  parameter int FRAC_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_cmd,
  input  logic signed [csev_pkg::X_W-1:0]     in_x,
  input  logic [csev_pkg::CNT_W-1:0]          in_term_count,
  input  logic [csev_pkg::TOL_W-1:0]          in_tolerance,
  output logic                                out_valid,
  output logic signed [csev_pkg::TERM_W-1:0]  out_series_sum,
  output logic signed [csev_pkg::TERM_W-1:0]  out_last_term,
  output logic [csev_pkg::CNT_W-1:0]          out_terms_added,
  output logic                                out_converged,
  output logic                                out_overflow
);

  localparam int TW    = csev_pkg::TERM_W;
  localparam int XW    = csev_pkg::X_W;
  localparam int X2W   = FRAC_BITS + 7;
  localparam int MBW   = (X2W > XW) ? X2W : XW;
  localparam int PW    = TW + MBW;
  localparam int CW    = $clog2(MAX_TERMS + 1);
  localparam int DW    = $clog2((2 * MAX_TERMS - 1) * (2 * MAX_TERMS) + 1);
  localparam int SQ_SH = 2 * csev_pkg::X_FRAC - FRAC_BITS;

  localparam csev_pkg::term_t ONE = csev_pkg::term_t'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQR,
    S_CHECK,
    S_DIV,
    S_MUL,
    S_ACC
  } state_t;

  state_t                       state_r;
  logic                         cmd_r;
  logic [csev_pkg::TOL_W-1:0]   tol_r;
  logic [CW-1:0]                upd_r;
  logic [XW-1:0]                ax_r;
  logic [X2W-1:0]               x2_r;
  logic [X2W-1:0]               r_r;
  csev_pkg::term_t              term_r;
  csev_pkg::term_t              sum_r;
  logic [CW-1:0]                n_r;
  logic                         ovf_r;
  logic                         conv_r;
  logic                         out_valid_r;
  logic                         mul_go_r;
  logic                         div_go_r;

  logic [XW-1:0]                ax_in;
  logic [csev_pkg::CNT_W-1:0]   cnt_m1;
  logic [CW-1:0]                upd_in;
  logic [TW-1:0]                term_mag;
  logic                         tol_miss;
  logic                         more;
  logic [TW-1:0]                mul_a;
  logic [MBW-1:0]               mul_b;
  logic                         mul_done;
  logic [PW-1:0]                prod;
  logic [CW:0]                  odd_f, even_f;
  logic [2*CW+1:0]              d_full;
  logic [DW-1:0]                den;
  logic                         div_done;
  logic [X2W-1:0]               quo;
  logic                         prod_hi_nz;
  logic [TW-1:0]                prod_mid;
  logic                         new_neg;
  logic                         term_sat;
  csev_pkg::term_t              term_new;
  logic signed [TW:0]           sum_wide;
  logic                         sum_sat;
  csev_pkg::term_t              sum_new;

  assign ax_in  = in_x[XW-1] ? (XW'(0) - $unsigned(in_x)) : $unsigned(in_x);
  assign cnt_m1 = (in_term_count > csev_pkg::CNT_W'(1)) ?
                  (in_term_count - csev_pkg::CNT_W'(1)) : '0;
  assign upd_in = (32'(cnt_m1) > MAX_TERMS) ? CW'(MAX_TERMS) : CW'(cnt_m1);

  assign term_mag = term_r[TW-1] ? (TW'(0) - $unsigned(term_r)) : $unsigned(term_r);
  assign tol_miss = term_mag > TW'(tol_r);
  assign more     = cmd_r ? (tol_miss && (n_r < CW'(MAX_TERMS))) : (n_r < upd_r);

  // The multiplier squares |x| first and later forms |term| * r.
  assign mul_a = (state_r == S_SQR) ? TW'(ax_r) : term_mag;
  assign mul_b = (state_r == S_SQR) ? MBW'(ax_r) : MBW'(r_r);

  csev_mul #(
    .B_W (MBW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mul_go_r),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  // Divisor (2n+1)(2n+2) for update n.
  assign odd_f  = {n_r, 1'b1};
  assign even_f = {n_r, 1'b0} + (CW+1)'(2);
  assign d_full = odd_f * even_f;
  assign den    = d_full[DW-1:0];

  csev_div #(
    .NUM_W (X2W),
    .DEN_W (DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go_r),
    .num   (x2_r),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  // The new term takes the opposite sign; a non-negative term turns negative.
  assign prod_hi_nz = |prod[PW-1:FRAC_BITS+TW];
  assign prod_mid   = prod[FRAC_BITS+TW-1:FRAC_BITS];
  assign new_neg    = !term_r[TW-1];

  always_comb begin
    if (new_neg) begin
      term_sat = prod_hi_nz || (prod_mid > $unsigned(csev_pkg::TERM_MIN));
      term_new = term_sat ? csev_pkg::TERM_MIN : csev_pkg::term_t'(TW'(0) - prod_mid);
    end else begin
      term_sat = prod_hi_nz || prod_mid[TW-1];
      term_new = term_sat ? csev_pkg::TERM_MAX : csev_pkg::term_t'(prod_mid);
    end
  end

  assign sum_wide = {sum_r[TW-1], sum_r} + {term_r[TW-1], term_r};
  assign sum_sat  = sum_wide[TW] != sum_wide[TW-1];
  assign sum_new  = !sum_sat ? sum_wide[TW-1:0] :
                    (sum_wide[TW] ? csev_pkg::TERM_MIN : csev_pkg::TERM_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mul_go_r    <= 1'b0;
      div_go_r    <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      mul_go_r    <= 1'b0;
      div_go_r    <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r    <= in_cmd;
            tol_r    <= in_tolerance;
            upd_r    <= upd_in;
            ax_r     <= ax_in;
            term_r   <= ONE;
            sum_r    <= ONE;
            n_r      <= '0;
            ovf_r    <= 1'b0;
            mul_go_r <= 1'b1;
            state_r  <= S_SQR;
          end
        end
        S_SQR: begin
          if (mul_done) begin
            x2_r    <= prod[SQ_SH +: X2W];
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (more) begin
            div_go_r <= 1'b1;
            state_r  <= S_DIV;
          end else begin
            conv_r      <= !cmd_r || !tol_miss;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            r_r      <= quo;
            mul_go_r <= 1'b1;
            state_r  <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            term_r <= term_new;
            if (term_sat) begin
              ovf_r <= 1'b1;
            end
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          sum_r <= sum_new;
          if (sum_sat) begin
            ovf_r <= 1'b1;
          end
          n_r     <= n_r + CW'(1);
          state_r <= S_CHECK;
        end
      endcase
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_series_sum  = sum_r;
  assign out_last_term   = term_r;
  assign out_terms_added = csev_pkg::CNT_W'(n_r);
  assign out_converged   = conv_r;
  assign out_overflow    = ovf_r;

`ifndef SYNTHESIS
  a_result_ends_transaction: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy))
    else $error("result strobe without a transaction in progress");

  a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_update_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (n_r <= CW'(MAX_TERMS)))
    else $error("term updates exceeded the limit");

  a_fixed_mode_converged: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !cmd_r) |-> (out_converged && (n_r == upd_r)))
    else $error("fixed-count transaction ended with a wrong count or flag");
`endif

endmodule

### test/tb_cosine_series_evaluator.sv
module tb_cosine_series_evaluator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TERMS    = 32;
  localparam int FRAC_BITS    = 32;
  localparam int RAND_ITEMS   = 950;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PRINT_CAP    = 100;

  localparam logic signed [63:0] SUM_HI  = csev_pkg::TERM_MAX;
  localparam logic signed [63:0] SUM_LO  = csev_pkg::TERM_MIN;
  localparam logic [63:0]        POS_LIM = SUM_HI;
  localparam logic [63:0]        NEG_LIM = POS_LIM + 64'd1;
  localparam csev_pkg::term_t    UNIT    = 48'sd1 <<< FRAC_BITS;
  localparam logic [46:0]        TOL_MAX = {47{1'b1}};

  typedef struct packed {
    logic                       cmd;
    logic [csev_pkg::X_W-1:0]   x;
    logic [csev_pkg::CNT_W-1:0] count;
    logic [csev_pkg::TOL_W-1:0] tol;
  } stim_t;

  typedef struct packed {
    csev_pkg::term_t            sum;
    csev_pkg::term_t            last;
    logic [csev_pkg::CNT_W-1:0] added;
    logic                       conv;
    logic                       ovf;
  } cos_result_t;

  typedef struct {
    int          idx;
    cos_result_t res;
  } pending_t;

  typedef struct {
    stim_t       stim;
    bit          known;
    cos_result_t res;
  } dir_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_cmd = 1'b0;
  logic signed [csev_pkg::X_W-1:0] in_x = '0;
  logic [csev_pkg::CNT_W-1:0] in_term_count = '0;
  logic [csev_pkg::TOL_W-1:0] in_tolerance = '0;
  logic out_valid;
  logic signed [csev_pkg::TERM_W-1:0] out_series_sum;
  logic signed [csev_pkg::TERM_W-1:0] out_last_term;
  logic [csev_pkg::CNT_W-1:0] out_terms_added;
  logic out_converged;
  logic out_overflow;

  pending_t cosine_q[$];
  dir_row_t dir_table[$];
  pending_t oldest;
  int mismatches = 0;
  int item_no = 0;
  int cycles = 0;

  cosine_series_evaluator #(
    .MAX_TERMS(MAX_TERMS),
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_cmd(in_cmd),
    .in_x(in_x),
    .in_term_count(in_term_count),
    .in_tolerance(in_tolerance),
    .out_valid(out_valid),
    .out_series_sum(out_series_sum),
    .out_last_term(out_last_term),
    .out_terms_added(out_terms_added),
    .out_converged(out_converged),
    .out_overflow(out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  // Sums the cosine series the way the block does: truncated squaring of x,
  // truncated division per step, magnitude truncation and 48-bit saturation.
  function automatic cos_result_t eval_cosine(input stim_t s);
    cos_result_t res;
    logic [63:0] ax, x2, dvs, r, mag;
    logic [127:0] prod;
    logic [127:0] shifted;
    logic signed [63:0] term, total;
    logic big, flip_neg, ovf;
    int n, updates;
    ax = s.x[31] ? 64'h1_0000_0000 - {32'b0, s.x} : {32'b0, s.x};
    x2 = (ax * ax) >> (56 - FRAC_BITS);
    term = 64'sd1 <<< FRAC_BITS;
    total = term;
    ovf = 1'b0;
    updates = (s.count > 1) ? s.count - 1 : 0;
    if (updates > MAX_TERMS) updates = MAX_TERMS;
    n = 0;
    while (s.cmd ? (abs64(term) > {17'b0, s.tol} && n < MAX_TERMS) : (n < updates)) begin
      dvs = 64'(2 * n + 1) * 64'(2 * n + 2);
      r = x2 / dvs;
      prod = {64'b0, abs64(term)} * {64'b0, r};
      shifted = prod >> FRAC_BITS;
      mag = shifted[63:0];
      big = |shifted[127:64];
      // The new term takes the opposite sign of the current one; zero counts as positive.
      flip_neg = !term[63];
      if (flip_neg) begin
        if (big || mag > NEG_LIM) begin
          term = SUM_LO;
          ovf = 1'b1;
        end else begin
          term = 64'sd0 - $signed(mag);
        end
      end else begin
        if (big || mag > POS_LIM) begin
          term = SUM_HI;
          ovf = 1'b1;
        end else begin
          term = $signed(mag);
        end
      end
      total = total + term;
      if (total > SUM_HI) begin
        total = SUM_HI;
        ovf = 1'b1;
      end else if (total < SUM_LO) begin
        total = SUM_LO;
        ovf = 1'b1;
      end
      n++;
    end
    res.sum = total[47:0];
    res.last = term[47:0];
    res.added = n[5:0];
    res.conv = s.cmd ? !(abs64(term) > {17'b0, s.tol}) : 1'b1;
    res.ovf = ovf;
    return res;
  endfunction

  function automatic stim_t random_stim();
    stim_t s;
    logic [63:0] wide;
    logic [31:0] small_mag;
    s.cmd = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: s.x = 32'h7FFF_FFFF;
          1: s.x = 32'h8000_0000;
          2: s.x = 32'h0000_0000;
          3: s.x = 32'h0000_0001;
          default: s.x = 32'hFFFF_FFFF;
        endcase
      end
      1, 2, 3: begin
        // Arguments within two radians keep the series well behaved.
        small_mag = $urandom_range(0, 32'h2000_0000);
        s.x = $urandom_range(0, 1) ? 32'd0 - small_mag : small_mag;
      end
      default: s.x = $urandom;
    endcase
    s.count = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) :
              6'($urandom_range(0, 33));
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: s.tol = '0;
      1: s.tol = TOL_MAX;
      2: s.tol = wide[46:0];
      default: s.tol = wide[46:0] >> $urandom_range(0, 46);
    endcase
    return s;
  endfunction

  task automatic report_mismatch(input string what, input int idx, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < PRINT_CAP)
      $display("MISMATCH item %0d %s: got %h, want %h", idx, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (cosine_q.size() == 0) begin
        report_mismatch("result with no transaction pending", -1, 64'(out_series_sum),
                        64'd0);
      end else begin
        oldest = cosine_q.pop_front();
        if (out_series_sum !== oldest.res.sum)
          report_mismatch("series_sum", oldest.idx, 64'(out_series_sum),
                          64'(oldest.res.sum));
        if (out_last_term !== oldest.res.last)
          report_mismatch("last_term", oldest.idx, 64'(out_last_term),
                          64'(oldest.res.last));
        if (out_terms_added !== oldest.res.added)
          report_mismatch("terms_added", oldest.idx, 64'(out_terms_added),
                          64'(oldest.res.added));
        if (out_converged !== oldest.res.conv)
          report_mismatch("converged", oldest.idx, 64'(out_converged),
                          64'(oldest.res.conv));
        if (out_overflow !== oldest.res.ovf)
          report_mismatch("overflow", oldest.idx, 64'(out_overflow),
                          64'(oldest.res.ovf));
      end
    end
  end

  // When align is set the idle gap is counted from the point the block is free,
  // so gaps also land after busy drops and not only while it is still computing.
  task automatic send_item(input stim_t s, input cos_result_t res, input int gap,
                           input bit align);
    if (gap > 0 || align) begin
      start <= 1'b0;
      if (align) begin
        do @(posedge clk); while (busy);
      end
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= s.cmd;
    in_x <= s.x;
    in_term_count <= s.count;
    in_tolerance <= s.tol;
    do @(posedge clk); while (busy);
    cosine_q.push_back('{idx: item_no, res: res});
    item_no++;
  endtask

  task automatic wait_all_done();
    start <= 1'b0;
    do @(posedge clk); while (cosine_q.size() != 0);
  endtask

  task automatic add_row(input logic cmd, input logic [31:0] x, input logic [5:0] count,
                         input logic [46:0] tol);
    dir_row_t row;
    row.stim = {cmd, x, count, tol};
    row.known = 1'b0;
    row.res = '0;
    dir_table.push_back(row);
  endtask

  // Rows whose outcome is plain: one, or a zero term after the first update.
  task automatic add_known(input logic cmd, input logic [31:0] x, input logic [5:0] count,
                           input logic [46:0] tol, input csev_pkg::term_t sum,
                           input csev_pkg::term_t last, input logic [5:0] added);
    dir_row_t row;
    row.stim = {cmd, x, count, tol};
    row.known = 1'b1;
    row.res.sum = sum;
    row.res.last = last;
    row.res.added = added;
    row.res.conv = 1'b1;
    row.res.ovf = 1'b0;
    dir_table.push_back(row);
  endtask

  initial begin
    stim_t s;
    cos_result_t res;
    int gap;
    bit align;
    bit burst;

    add_known(1'b0, 32'h0000_0000, 6'd0, 47'd0, UNIT, UNIT, 6'd0);
    add_known(1'b0, 32'h7FFF_FFFF, 6'd1, TOL_MAX, UNIT, UNIT, 6'd0);
    add_known(1'b0, 32'h8000_0000, 6'd0, 47'd0, UNIT, UNIT, 6'd0);
    add_known(1'b1, 32'h8000_0000, 6'd0, TOL_MAX, UNIT, UNIT, 6'd0);
    add_known(1'b1, 32'h3243_F6A8, 6'd5, 47'h1_0000_0000, UNIT, UNIT, 6'd0);
    add_known(1'b0, 32'h0000_0000, 6'd63, 47'd0, UNIT, 48'sd0, 6'd32);
    add_known(1'b1, 32'h0000_0000, 6'd0, 47'd0, UNIT, 48'sd0, 6'd1);
    add_row(1'b0, 32'h7FFF_FFFF, 6'd2, 47'd0);
    add_row(1'b0, 32'h7FFF_FFFF, 6'd3, 47'd0);
    add_row(1'b0, 32'h7FFF_FFFF, 6'd32, 47'd0);
    add_row(1'b0, 32'h7FFF_FFFF, 6'd33, 47'd0);
    add_row(1'b0, 32'h8000_0000, 6'd33, 47'd0);
    add_row(1'b0, 32'h8000_0000, 6'd63, 47'd0);
    add_row(1'b1, 32'h7FFF_FFFF, 6'd0, 47'd0);
    add_row(1'b1, 32'h8000_0000, 6'd63, 47'd0);
    add_row(1'b1, 32'h8000_0000, 6'd0, 47'd1);
    add_row(1'b1, 32'h0000_0001, 6'd0, 47'd0);
    add_row(1'b1, 32'hFFFF_FFFF, 6'd0, 47'd0);
    add_row(1'b1, 32'h3243_F6A8, 6'd0, 47'h0_FFFF_FFFF);
    add_row(1'b0, 32'h1921_FB54, 6'd10, 47'd0);
    add_row(1'b0, 32'h5555_5555, 6'd21, 47'h2AAA_AAAA_AAAA);
    add_row(1'b0, 32'hAAAA_AAAA, 6'd42, 47'h5555_5555_5555);
    add_row(1'b1, 32'h5555_5555, 6'd42, 47'h0000_0555_5555);
    add_row(1'b1, 32'hAAAA_AAAA, 6'd21, 47'h0000_0000_AAAA);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      res = dir_table[i].known ? dir_table[i].res : eval_cosine(dir_table[i].stim);
      send_item(dir_table[i].stim, res, $urandom_range(0, 5), 1'($urandom_range(0, 1)));
    end

    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k == RAND_ITEMS / 2) wait_all_done();
      s = random_stim();
      burst = (k % 150) >= 120;
      gap = burst ? 0 : $urandom_range(0, 5);
      align = burst ? 1'b0 : 1'($urandom_range(0, 1));
      send_item(s, eval_cosine(s), gap, align);
    end

    wait_all_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
rtl/csev_pkg.sv
rtl/csev_div.sv
rtl/csev_mul.sv
rtl/cosine_series_evaluator.sv
test/tb_cosine_series_evaluator.sv
